// ===== src/cmg_pkg.sv =====
// Shared constants, codes and word types of the cylinder mesh generator.
package cmg_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_SEGMENTS = 256;
    localparam int Q_BITS       = 30;
    localparam int NUM_TERMS    = 7;

    localparam int RADIUS_W = 12;
    localparam int HEIGHT_W = 13;
    localparam int COUNT_W  = 9;
    localparam int INDEX_W  = 9;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 30;
    localparam int FIX_W    = FRAC_BITS + 2;
    localparam int TEX_W    = FRAC_BITS + 1;
    localparam int VNUM_W   = 11;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W  = 32;
    localparam int DIV_W    = INDEX_W + PHASE_W;

    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd1;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd2;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 9'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_SIDE   = 2'd0,
        CMD_TOP    = 2'd1,
        CMD_BOTTOM = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COUNT  = 2'd2
    } cfg_reg_t;

    // Series divisors for terms one through seven, with floor(2^32 / d).
    localparam logic [7:0] SIN_DIV [NUM_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                                   8'd110, 8'd156, 8'd210};
    localparam logic [7:0] COS_DIV [NUM_TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56,
                                                   8'd90, 8'd132, 8'd182};
    localparam logic [31:0] SIN_RECIP [NUM_TERMS] = '{32'd715827882, 32'd214748364,
        32'd102261126, 32'd59652323, 32'd39045157, 32'd27531841, 32'd20452225};
    localparam logic [31:0] COS_RECIP [NUM_TERMS] = '{32'd2147483648, 32'd357913941,
        32'd143165576, 32'd76695844, 32'd47721858, 32'd32537631, 32'd23598721};

    typedef struct packed {
        cmd_t               cmd;
        logic [INDEX_W-1:0] index;
    } div_tag_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [INDEX_W-1:0] index;
        logic [TEX_W-1:0]   tex_q;
    } trig_tag_t;

endpackage

// ===== src/cmg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two dividends per divisor.
module cmg_div
    import cmg_pkg::*;
#(
    parameter int DW = DIV_W,
    parameter int VW = COUNT_W,
    parameter int TW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_num_a,
    input  logic [DW-1:0] in_num_b,
    input  logic [VW-1:0] in_den,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [DW-1:0] out_quo_a,
    output logic [DW-1:0] out_quo_b,
    output logic [TW-1:0] out_tag
);

    logic          v_reg      [DW];
    logic [VW-1:0] rem_a_reg  [DW];
    logic [VW-1:0] rem_b_reg  [DW];
    logic [DW-1:0] work_a_reg [DW];
    logic [DW-1:0] work_b_reg [DW];
    logic [VW-1:0] den_reg    [DW];
    logic [TW-1:0] tag_reg    [DW];

    function automatic logic [VW+DW-1:0] div_step(logic [VW-1:0] rem, logic [DW-1:0] work,
                                                 logic [VW-1:0] den);
        logic [VW:0] trial;
        logic [VW:0] diff;
        logic        q;
        trial = {rem, work[DW-1]};
        if (trial >= {1'b0, den})
        begin
            diff = trial - {1'b0, den};
            q    = 1'b1;
        end
        else
        begin
            diff = trial;
            q    = 1'b0;
        end
        return {diff[VW-1:0], work[DW-2:0], q};
    endfunction

    for (genvar j = 0; j < DW; j++)
    begin : g_stage
        logic          src_v;
        logic [VW-1:0] src_rem_a;
        logic [VW-1:0] src_rem_b;
        logic [DW-1:0] src_work_a;
        logic [DW-1:0] src_work_b;
        logic [VW-1:0] src_den;
        logic [TW-1:0] src_tag;
        logic [VW+DW-1:0] step_a;
        logic [VW+DW-1:0] step_b;

        if (j == 0)
        begin : g_first
            assign src_v      = in_valid;
            assign src_rem_a  = '0;
            assign src_rem_b  = '0;
            assign src_work_a = in_num_a;
            assign src_work_b = in_num_b;
            assign src_den    = in_den;
            assign src_tag    = in_tag;
        end
        else
        begin : g_next
            assign src_v      = v_reg[j-1];
            assign src_rem_a  = rem_a_reg[j-1];
            assign src_rem_b  = rem_b_reg[j-1];
            assign src_work_a = work_a_reg[j-1];
            assign src_work_b = work_b_reg[j-1];
            assign src_den    = den_reg[j-1];
            assign src_tag    = tag_reg[j-1];
        end

        assign step_a = div_step(src_rem_a, src_work_a, src_den);
        assign step_b = div_step(src_rem_b, src_work_b, src_den);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[j]  <= step_a[VW+DW-1:DW];
                work_a_reg[j] <= step_a[DW-1:0];
                rem_b_reg[j]  <= step_b[VW+DW-1:DW];
                work_b_reg[j] <= step_b[DW-1:0];
                den_reg[j]    <= src_den;
                tag_reg[j]    <= src_tag;
            end
        end
    end

    assign out_valid = v_reg[DW-1];
    assign out_quo_a = work_a_reg[DW-1];
    assign out_quo_b = work_b_reg[DW-1];
    assign out_tag   = tag_reg[DW-1];

endmodule

// ===== src/cmg_trig.sv =====
// Pipelined sine and cosine of a turn fraction by octant folding and Taylor series.
module cmg_trig
    import cmg_pkg::*;
#(
    parameter int TW = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [PHASE_W-1:0]      in_phase,
    input  logic [TW-1:0]           in_tag,
    output logic                    out_valid,
    output logic signed [FIX_W-1:0] out_sin,
    output logic signed [FIX_W-1:0] out_cos,
    output logic [TW-1:0]           out_tag
);

    localparam int SH = Q_BITS - FRAC_BITS;

    typedef struct packed {
        logic [2:0]         oct;
        logic [29:0]        x2;
        logic signed [32:0] sum_s;
        logic signed [32:0] sum_c;
        logic [TW-1:0]      tag;
    } carry_t;

    // Stage 0: fold into one octant and scale to radians.
    logic        s0_v_reg;
    logic [2:0]  s0_oct_reg;
    logic [61:0] s0_prod_reg;
    logic [TW-1:0] s0_tag_reg;
    logic [29:0] fold_r;
    logic [61:0] s0_prod_next;

    always_comb
    begin
        if (in_phase[29])
        begin
            fold_r = 30'h2000_0000 - {1'b0, in_phase[28:0]};
        end
        else
        begin
            fold_r = {1'b0, in_phase[28:0]};
        end
        s0_prod_next = fold_r * PI_Q30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_oct_reg  <= in_phase[31:29];
            s0_prod_reg <= s0_prod_next;
            s0_tag_reg  <= in_tag;
        end
    end

    // Stage 1: angle and its square.
    logic          s1_v_reg;
    logic [2:0]    s1_oct_reg;
    logic [30:0]   s1_a_reg;
    logic [61:0]   s1_sq_reg;
    logic [TW-1:0] s1_tag_reg;
    logic [30:0]   s1_a_next;
    logic [61:0]   s1_sq_next;

    assign s1_a_next  = s0_prod_reg[61:31];
    assign s1_sq_next = s1_a_next * s1_a_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_oct_reg <= s0_oct_reg;
            s1_a_reg   <= s1_a_next;
            s1_sq_reg  <= s1_sq_next;
            s1_tag_reg <= s0_tag_reg;
        end
    end

    // Term stages. Entry zero holds the leading terms; entry k+1 follows term k.
    logic        c_v_reg  [NUM_TERMS+1];
    carry_t      c_car_reg [NUM_TERMS+1];
    logic [30:0] c_ts_reg [NUM_TERMS+1];
    logic [30:0] c_tc_reg [NUM_TERMS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg[0] <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_car_reg[0].oct   <= s1_oct_reg;
            c_car_reg[0].x2    <= s1_sq_reg[59:30];
            c_car_reg[0].sum_s <= $signed({2'b00, s1_a_reg});
            c_car_reg[0].sum_c <= $signed(33'(1) << Q_BITS);
            c_car_reg[0].tag   <= s1_tag_reg;
            c_ts_reg[0]        <= s1_a_reg;
            c_tc_reg[0]        <= 31'(1) << Q_BITS;
        end
    end

    for (genvar k = 0; k < NUM_TERMS; k++)
    begin : g_term
        logic        a_v_reg;
        carry_t      a_car_reg;
        logic [60:0] a_ps_reg;
        logic [60:0] a_pc_reg;
        logic        b_v_reg;
        carry_t      b_car_reg;
        logic [30:0] b_ns_reg;
        logic [30:0] b_nc_reg;
        logic [62:0] b_ms_reg;
        logic [62:0] b_mc_reg;
        logic [30:0] ns;
        logic [30:0] nc;
        logic [30:0] q0s;
        logic [30:0] q0c;
        logic [38:0] rs;
        logic [38:0] rc;
        logic [30:0] qs;
        logic [30:0] qc;
        carry_t      c_next;

        assign ns  = a_ps_reg[60:30];
        assign nc  = a_pc_reg[60:30];
        assign q0s = b_ms_reg[62:32];
        assign q0c = b_mc_reg[62:32];
        assign rs  = {8'd0, b_ns_reg} - q0s * SIN_DIV[k];
        assign rc  = {8'd0, b_nc_reg} - q0c * COS_DIV[k];
        assign qs  = q0s + 31'(rs >= {31'd0, SIN_DIV[k]});
        assign qc  = q0c + 31'(rc >= {31'd0, COS_DIV[k]});

        always_comb
        begin
            c_next = b_car_reg;
            if ((k % 2) == 0)
            begin
                c_next.sum_s = b_car_reg.sum_s - $signed({2'b00, qs});
                c_next.sum_c = b_car_reg.sum_c - $signed({2'b00, qc});
            end
            else
            begin
                c_next.sum_s = b_car_reg.sum_s + $signed({2'b00, qs});
                c_next.sum_c = b_car_reg.sum_c + $signed({2'b00, qc});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_v_reg      <= 1'b0;
                b_v_reg      <= 1'b0;
                c_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                a_v_reg      <= c_v_reg[k];
                b_v_reg      <= a_v_reg;
                c_v_reg[k+1] <= b_v_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_car_reg      <= c_car_reg[k];
                a_ps_reg       <= c_ts_reg[k] * c_car_reg[k].x2;
                a_pc_reg       <= c_tc_reg[k] * c_car_reg[k].x2;
                b_car_reg      <= a_car_reg;
                b_ns_reg       <= ns;
                b_nc_reg       <= nc;
                b_ms_reg       <= ns * SIN_RECIP[k];
                b_mc_reg       <= nc * COS_RECIP[k];
                c_car_reg[k+1] <= c_next;
                c_ts_reg[k+1]  <= qs;
                c_tc_reg[k+1]  <= qc;
            end
        end
    end

    // Final stage: round to the output format and unfold the octant.
    logic                    f_v_reg;
    logic signed [FIX_W-1:0] f_sin_reg;
    logic signed [FIX_W-1:0] f_cos_reg;
    logic [TW-1:0]           f_tag_reg;
    carry_t                  last_car;
    logic [31:0]             rnd_s;
    logic [31:0]             rnd_c;
    logic signed [FIX_W-1:0] mag_s;
    logic signed [FIX_W-1:0] mag_c;
    logic signed [FIX_W-1:0] sin_next;
    logic signed [FIX_W-1:0] cos_next;
    logic [2:0]              oct;

    assign last_car = c_car_reg[NUM_TERMS];
    assign oct      = last_car.oct;

    always_comb
    begin
        rnd_s = (last_car.sum_s[32] ? 32'd0 : last_car.sum_s[31:0]) + (32'(1) << (SH - 1));
        rnd_c = (last_car.sum_c[32] ? 32'd0 : last_car.sum_c[31:0]) + (32'(1) << (SH - 1));
        mag_s = $signed({1'b0, rnd_s[30:SH]});
        mag_c = $signed({1'b0, rnd_c[30:SH]});
        if (oct == 3'd1 || oct == 3'd2 || oct == 3'd5 || oct == 3'd6)
        begin
            sin_next = mag_c;
            cos_next = mag_s;
        end
        else
        begin
            sin_next = mag_s;
            cos_next = mag_c;
        end
        if (oct[2])
        begin
            sin_next = -sin_next;
        end
        if (oct == 3'd2 || oct == 3'd3 || oct == 3'd4 || oct == 3'd5)
        begin
            cos_next = -cos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= c_v_reg[NUM_TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_sin_reg <= sin_next;
            f_cos_reg <= cos_next;
            f_tag_reg <= last_car.tag;
        end
    end

    assign out_valid = f_v_reg;
    assign out_sin   = f_sin_reg;
    assign out_cos   = f_cos_reg;
    assign out_tag   = f_tag_reg;

endmodule

// ===== src/cmg_emit.sv =====
// Builds the vertex and index records of a segment and sends them one word per cycle while out_ready is high.
module cmg_emit
    import cmg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [FIX_W-1:0] in_sin,
    input  logic signed [FIX_W-1:0] in_cos,
    input  trig_tag_t               in_tag,
    input  logic [RADIUS_W-1:0]     radius,
    input  logic [HEIGHT_W-1:0]     full_height,
    input  logic [COUNT_W-1:0]      segment_count,
    output logic                    en,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    item_kind,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic signed [POS_W-1:0] pos_z,
    output logic signed [FIX_W-1:0] normal_x,
    output logic signed [FIX_W-1:0] normal_y,
    output logic signed [FIX_W-1:0] normal_z,
    output logic [TEX_W-1:0]        tex_u,
    output logic [TEX_W-1:0]        tex_v,
    output logic [VNUM_W-1:0]       vertex_number,
    output logic                    last
);

    localparam logic [TEX_W-1:0]        ONE_U = TEX_W'(1) << FRAC_BITS;
    localparam logic signed [FIX_W-1:0] ONE_N = FIX_W'(1) << FRAC_BITS;
    localparam logic signed [FIX_W:0]   ONE_W = (FIX_W + 1)'(1) << FRAC_BITS;

    logic                    ser_v_reg;
    logic [2:0]              cnt_reg;
    logic [2:0]              last_k_reg;
    logic                    side_reg;
    logic                    tri_reg;
    logic signed [POS_W-1:0] x_reg;
    logic signed [POS_W-1:0] y_reg;
    logic signed [POS_W-1:0] yb_reg;
    logic signed [POS_W-1:0] z_reg;
    logic signed [FIX_W-1:0] nx_reg;
    logic signed [FIX_W-1:0] ny_reg;
    logic signed [FIX_W-1:0] nz_reg;
    logic [TEX_W-1:0]        u_reg;
    logic [TEX_W-1:0]        v_reg;
    logic [TEX_W-1:0]        vb_reg;
    logic [VNUM_W-1:0]       idx_reg [6];

    logic                    ser_v_next;
    logic [2:0]              cnt_next;
    logic                    is_last;
    logic                    is_side;
    logic                    is_top;
    logic                    has_tri;
    logic signed [30:0]      x_full;
    logic signed [30:0]      z_full;
    logic signed [POS_W-1:0] half_h;
    logic signed [FIX_W:0]   sin_w;
    logic signed [FIX_W:0]   cos_w;
    logic signed [FIX_W:0]   cap_u;
    logic signed [FIX_W:0]   cap_v;
    logic [VNUM_W-1:0]       i_w;
    logic [VNUM_W-1:0]       t_w;
    logic [VNUM_W-1:0]       base;
    logic [VNUM_W-1:0]       w2;
    logic [VNUM_W-1:0]       w3;
    logic [VNUM_W-1:0]       idx_next [6];
    logic [2:0]              last_k_next;

    assign is_last = cnt_reg == last_k_reg;
    assign en      = !ser_v_reg || (out_ready && is_last);

    always_comb
    begin
        is_side = in_tag.cmd == CMD_SIDE;
        is_top  = in_tag.cmd == CMD_TOP;
        x_full  = $signed({1'b0, radius}) * in_sin;
        z_full  = $signed({1'b0, radius}) * in_cos;
        half_h  = $signed({2'b00, full_height, {(FRAC_BITS - 1){1'b0}}});
        sin_w   = {in_sin[FIX_W-1], in_sin};
        cos_w   = {in_cos[FIX_W-1], in_cos};
        cap_u   = ONE_W + (is_top ? sin_w : -sin_w) + (FIX_W + 1)'(1);
        cap_v   = ONE_W - cos_w + (FIX_W + 1)'(1);
        i_w     = {2'b00, in_tag.index};
        t_w     = {2'b00, segment_count};
        has_tri = (i_w + VNUM_W'(2)) < t_w;
        w2      = (in_tag.index == segment_count) ? VNUM_W'(0) : (i_w << 1) + VNUM_W'(2);
        w3      = (in_tag.index == segment_count) ? VNUM_W'(1) : (i_w << 1) + VNUM_W'(3);
        base    = is_top ? (t_w << 1) + VNUM_W'(2) : (t_w << 1) + t_w + VNUM_W'(2);
        if (is_side)
        begin
            idx_next[0] = (i_w << 1) + VNUM_W'(1);
            idx_next[1] = w2;
            idx_next[2] = i_w << 1;
            idx_next[3] = w3;
            idx_next[4] = w2;
            idx_next[5] = (i_w << 1) + VNUM_W'(1);
            last_k_next = 3'd7;
        end
        else
        begin
            idx_next[0] = base;
            idx_next[1] = base + (is_top ? i_w + VNUM_W'(2) : i_w + VNUM_W'(1));
            idx_next[2] = base + (is_top ? i_w + VNUM_W'(1) : i_w + VNUM_W'(2));
            idx_next[3] = '0;
            idx_next[4] = '0;
            idx_next[5] = '0;
            last_k_next = has_tri ? 3'd3 : 3'd0;
        end
    end

    always_comb
    begin
        ser_v_next = ser_v_reg;
        cnt_next   = cnt_reg;
        if (en)
        begin
            ser_v_next = in_valid;
            cnt_next   = '0;
        end
        else if (out_ready)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_v_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            ser_v_reg <= ser_v_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg   <= is_side;
            tri_reg    <= has_tri;
            last_k_reg <= last_k_next;
            x_reg      <= x_full[POS_W-1:0];
            z_reg      <= z_full[POS_W-1:0];
            y_reg      <= (is_side || is_top) ? half_h : -half_h;
            yb_reg     <= -half_h;
            nx_reg     <= is_side ? in_sin : '0;
            ny_reg     <= is_side ? '0 : (is_top ? ONE_N : -ONE_N);
            nz_reg     <= is_side ? in_cos : '0;
            u_reg      <= is_side ? ONE_U - in_tag.tex_q : cap_u[FRAC_BITS+1:1];
            v_reg      <= is_side ? '0 : cap_v[FRAC_BITS+1:1];
            vb_reg     <= ONE_U;
            for (int n = 0; n < 6; n++)
            begin
                idx_reg[n] <= idx_next[n];
            end
        end
    end

    logic       rec_index;
    logic [2:0] sel;

    always_comb
    begin
        rec_index     = 1'b0;
        sel           = '0;
        item_kind     = 1'b0;
        pos_x         = x_reg;
        pos_y         = y_reg;
        pos_z         = z_reg;
        normal_x      = nx_reg;
        normal_y      = ny_reg;
        normal_z      = nz_reg;
        tex_u         = u_reg;
        tex_v         = v_reg;
        vertex_number = '0;
        if (side_reg)
        begin
            case (cnt_reg)
                3'd0:
                begin
                end
                3'd1:
                begin
                    pos_y = yb_reg;
                    tex_v = vb_reg;
                end
                default:
                begin
                    rec_index = 1'b1;
                    sel       = cnt_reg - 3'd2;
                end
            endcase
        end
        else if (tri_reg && cnt_reg < 3'd3)
        begin
            rec_index = 1'b1;
            sel       = cnt_reg;
        end
        if (rec_index)
        begin
            item_kind     = 1'b1;
            pos_x         = '0;
            pos_y         = '0;
            pos_z         = '0;
            normal_x      = '0;
            normal_y      = '0;
            normal_z      = '0;
            tex_u         = '0;
            tex_v         = '0;
            vertex_number = idx_reg[sel];
        end
        last = is_last;
    end

    assign out_valid = ser_v_reg;

endmodule

// ===== src/cylinder_mesh_generator.sv =====
// Top level of the cylinder mesh generator: configuration, range checks and the pipeline.
// Result words leave one per cycle while out_ready is high; a side segment gives eight,
// a cap segment four or one. The pipeline takes a word every cycle while the output
// serializer is free, so a stream of side segments is paced by the output serializer.
// Reset empties the pipeline and sets radius 1, full height 2 and segment count 16.
module cylinder_mesh_generator
    import cmg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CMD_W-1:0]        command,
    input  logic [INDEX_W-1:0]      segment_index,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    item_kind,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic signed [POS_W-1:0] pos_z,
    output logic signed [FIX_W-1:0] normal_x,
    output logic signed [FIX_W-1:0] normal_y,
    output logic signed [FIX_W-1:0] normal_z,
    output logic [TEX_W-1:0]        tex_u,
    output logic [TEX_W-1:0]        tex_v,
    output logic [VNUM_W-1:0]       vertex_number,
    output logic                    last
);

    logic [RADIUS_W-1:0] radius_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COUNT_W-1:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            height_reg <= HEIGHT_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    logic             en;
    logic             word_ok;
    logic             div_in_valid;
    div_tag_t         div_tag_in;
    logic [DIV_W-1:0] num_a;
    logic [DIV_W-1:0] num_b;
    cmd_t             cmd;

    assign cmd = cmd_t'(command);

    always_comb
    begin
        word_ok = (count_reg >= COUNT_W'(3)) && (count_reg <= COUNT_W'(MAX_SEGMENTS));
        unique case (cmd)
            CMD_SIDE:             word_ok = word_ok && (segment_index <= count_reg);
            CMD_TOP, CMD_BOTTOM:  word_ok = word_ok && (segment_index < count_reg);
            default:              word_ok = 1'b0;
        endcase
    end

    assign in_ready     = en;
    assign div_in_valid = in_valid && en && word_ok;
    assign div_tag_in   = '{cmd: cmd, index: segment_index};
    assign num_a = {segment_index, {(PHASE_W - COUNT_W + 1){1'b0}}, count_reg[COUNT_W-1:1]};
    assign num_b = {{(PHASE_W - FRAC_BITS){1'b0}}, segment_index,
                    {(FRAC_BITS - COUNT_W + 1){1'b0}}, count_reg[COUNT_W-1:1]};

    logic             div_out_valid;
    logic [DIV_W-1:0] quo_a;
    logic [DIV_W-1:0] quo_b;
    div_tag_t         div_tag_out;
    trig_tag_t        trig_tag_in;

    cmg_div #(
        .DW (DIV_W),
        .VW (COUNT_W),
        .TW ($bits(div_tag_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_in_valid),
        .in_num_a  (num_a),
        .in_num_b  (num_b),
        .in_den    (count_reg),
        .in_tag    (div_tag_in),
        .out_valid (div_out_valid),
        .out_quo_a (quo_a),
        .out_quo_b (quo_b),
        .out_tag   (div_tag_out)
    );

    assign trig_tag_in = '{cmd: div_tag_out.cmd, index: div_tag_out.index,
                           tex_q: quo_b[TEX_W-1:0]};

    logic                    trig_valid;
    logic signed [FIX_W-1:0] trig_sin;
    logic signed [FIX_W-1:0] trig_cos;
    trig_tag_t               trig_tag_out;

    cmg_trig #(
        .TW ($bits(trig_tag_t))
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_out_valid),
        .in_phase  (quo_a[PHASE_W-1:0]),
        .in_tag    (trig_tag_in),
        .out_valid (trig_valid),
        .out_sin   (trig_sin),
        .out_cos   (trig_cos),
        .out_tag   (trig_tag_out)
    );

    cmg_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (trig_valid),
        .in_sin        (trig_sin),
        .in_cos        (trig_cos),
        .in_tag        (trig_tag_out),
        .radius        (radius_reg),
        .full_height   (height_reg),
        .segment_count (count_reg),
        .en            (en),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_kind     (item_kind),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .vertex_number (vertex_number),
        .last          (last)
    );

endmodule
